/* rtl/kmst_pkg.sv */
// Package with shared constants and types for the spanning tree block.
package kmst_pkg;
    localparam int MAX_VERTICES = 32;
    localparam int MAX_EDGES    = 256;
    localparam int WEIGHT_BITS  = 16;
    localparam int VBITS        = $clog2(MAX_VERTICES);
    localparam int EBITS        = $clog2(MAX_EDGES);
    localparam int CBITS        = EBITS + 1;
    localparam int COST_BITS    = 21;
    localparam int VCOUNT_BITS  = 6;
    localparam int RANK_BITS    = 3;
    localparam logic [COST_BITS-1:0] COST_MAX = {COST_BITS{1'b1}};

    typedef struct packed {
        logic [VBITS-1:0]       a;
        logic [VBITS-1:0]       b;
        logic [WEIGHT_BITS-1:0] w;
    } edge_t;

    typedef struct packed {
        logic [VBITS-1:0]       vertex_a;
        logic [VBITS-1:0]       vertex_b;
        logic [WEIGHT_BITS-1:0] weight;
        logic                   last_edge;
    } in_word_t;

    typedef struct packed {
        logic [VBITS-1:0]       tree_vertex_a;
        logic [VBITS-1:0]       tree_vertex_b;
        logic [WEIGHT_BITS-1:0] tree_weight;
        logic [COST_BITS-1:0]   total_cost;
        logic                   dropped_flag;
        logic                   is_summary;
    } out_word_t;
endpackage

/* rtl/kmst_if.sv */
// Valid and ready channel interfaces for edge, result and configuration words.
interface kmst_in_if;
    logic                 valid;
    logic                 ready;
    kmst_pkg::in_word_t   data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface kmst_out_if;
    logic                 valid;
    logic                 ready;
    kmst_pkg::out_word_t  data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface kmst_cfg_if;
    logic                                 valid;
    logic                                 ready;
    logic [kmst_pkg::VCOUNT_BITS-1:0]     data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

/* rtl/kruskal_minimum_spanning_tree.sv */
// Top level of the spanning tree block: edge store, insertion sort and union-find sequencer.
// Loading takes one edge word per cycle with no gap; ready falls after the last edge word.
// Sort: insertion sort by weight, each stored edge is taken as key and heavier edges move up one place.
// Union-find: per edge, read it, walk to the roots of a and b, join and emit a tree edge; output stalls hold it.
// Each result word waits in one output register; ready returns once the summary is loaded.
// Reset is asynchronous and active low; the forest is rebuilt at the start of every run.
module kruskal_minimum_spanning_tree
(
    input  logic          clk,
    input  logic          rst_n,
    kmst_in_if.sink       in_ch,
    kmst_out_if.source    out_ch,
    kmst_cfg_if.sink      cfg
);
    import kmst_pkg::*;

    typedef enum logic [3:0] {
        S_LOAD, S_SORT_RD, S_SORT_KEY, S_SORT_RDP, S_SORT_CMP, S_SORT_PUT, S_INIT,
        S_EDGE_RD, S_EDGE_GET, S_FIND_A, S_FIND_B, S_JOIN, S_EMIT, S_SUM
    } state_t;

    state_t state_reg;
    edge_t mem [MAX_EDGES];
    edge_t rd_reg;
    edge_t key_reg;
    edge_t cur_reg;
    logic [CBITS-1:0] count_reg;
    logic [CBITS-1:0] i_reg;
    logic [CBITS-1:0] j_reg;
    logic [COST_BITS-1:0] cost_reg;
    logic drop_reg;
    logic [VCOUNT_BITS-1:0] vcount_reg;
    logic [VBITS-1:0] parent_reg [MAX_VERTICES];
    logic [RANK_BITS-1:0] rank_reg [MAX_VERTICES];
    logic [VBITS-1:0] walk_reg;
    logic [VBITS-1:0] ra_reg;
    logic [VBITS:0] n_reg;
    logic out_valid_reg;
    out_word_t out_reg;
    logic [COST_BITS:0] sum_w;
    logic bad_w;
    logic in_acc;
    logic shift_w;
    logic out_load;
    logic [EBITS-1:0] rd_addr_w;

    assign in_ch.ready = (state_reg == S_LOAD);
    assign cfg.ready = 1'b1;
    assign out_ch.valid = out_valid_reg;
    assign out_ch.data = out_reg;
    assign in_acc = in_ch.valid && in_ch.ready;
    assign bad_w = ({1'b0, in_ch.data.vertex_a} >= vcount_reg)
        || ({1'b0, in_ch.data.vertex_b} >= vcount_reg)
        || (count_reg == CBITS'(MAX_EDGES));
    assign sum_w = {1'b0, cost_reg} + (COST_BITS+1)'(cur_reg.w);
    assign shift_w = (rd_reg.w > key_reg.w);
    assign out_load = ((state_reg == S_EMIT) || (state_reg == S_SUM))
        && (!out_valid_reg || out_ch.ready);
    assign rd_addr_w = ((state_reg == S_EDGE_RD) || (state_reg == S_SORT_RD))
        ? i_reg[EBITS-1:0] : EBITS'(j_reg - 1'b1);

    always_ff @(posedge clk)
    begin
        if (in_acc && !bad_w)
        begin
            mem[count_reg[EBITS-1:0]] <= '{in_ch.data.vertex_a, in_ch.data.vertex_b,
                                           in_ch.data.weight};
        end
        else if (state_reg == S_SORT_CMP && shift_w)
        begin
            mem[j_reg[EBITS-1:0]] <= rd_reg;
        end
        else if (state_reg == S_SORT_PUT)
        begin
            mem[j_reg[EBITS-1:0]] <= key_reg;
        end
        rd_reg <= mem[rd_addr_w];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_LOAD;
            count_reg <= '0;
            cost_reg <= '0;
            drop_reg <= 1'b0;
            vcount_reg <= VCOUNT_BITS'(MAX_VERTICES);
            out_valid_reg <= 1'b0;
            out_reg <= '0;
            key_reg <= '0;
            cur_reg <= '0;
            walk_reg <= '0;
            ra_reg <= '0;
            i_reg <= '0;
            j_reg <= '0;
            n_reg <= '0;
        end
        else
        begin
            if (cfg.valid)
            begin
                vcount_reg <= cfg.data;
            end
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ch.ready)
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_LOAD:
                begin
                    if (in_acc)
                    begin
                        if (bad_w)
                        begin
                            drop_reg <= 1'b1;
                        end
                        else
                        begin
                            count_reg <= count_reg + 1'b1;
                        end
                        if (in_ch.data.last_edge)
                        begin
                            i_reg <= CBITS'(1);
                            j_reg <= CBITS'(1);
                            state_reg <= S_SORT_RD;
                        end
                    end
                end
                S_SORT_RD:
                begin
                    if (i_reg >= count_reg)
                    begin
                        state_reg <= S_INIT;
                    end
                    else
                    begin
                        state_reg <= S_SORT_KEY;
                    end
                end
                S_SORT_KEY:
                begin
                    key_reg <= rd_reg;
                    state_reg <= S_SORT_CMP;
                end
                S_SORT_RDP:
                begin
                    state_reg <= S_SORT_CMP;
                end
                S_SORT_CMP:
                begin
                    if (shift_w)
                    begin
                        j_reg <= j_reg - 1'b1;
                        state_reg <= (j_reg == CBITS'(1)) ? S_SORT_PUT : S_SORT_RDP;
                    end
                    else
                    begin
                        state_reg <= S_SORT_PUT;
                    end
                end
                S_SORT_PUT:
                begin
                    i_reg <= i_reg + 1'b1;
                    j_reg <= i_reg + 1'b1;
                    state_reg <= S_SORT_RD;
                end
                S_INIT:
                begin
                    i_reg <= '0;
                    n_reg <= '0;
                    cost_reg <= '0;
                    state_reg <= S_EDGE_RD;
                end
                S_EDGE_RD:
                begin
                    state_reg <= (i_reg >= count_reg || n_reg == (VBITS+1)'(MAX_VERTICES - 1))
                        ? S_SUM : S_EDGE_GET;
                end
                S_EDGE_GET:
                begin
                    cur_reg <= rd_reg;
                    walk_reg <= rd_reg.a;
                    state_reg <= S_FIND_A;
                end
                S_FIND_A:
                begin
                    if (parent_reg[walk_reg] == walk_reg)
                    begin
                        ra_reg <= walk_reg;
                        walk_reg <= cur_reg.b;
                        state_reg <= S_FIND_B;
                    end
                    else
                    begin
                        walk_reg <= parent_reg[walk_reg];
                    end
                end
                S_FIND_B:
                begin
                    if (parent_reg[walk_reg] == walk_reg)
                    begin
                        i_reg <= i_reg + 1'b1;
                        state_reg <= (walk_reg != ra_reg) ? S_JOIN : S_EDGE_RD;
                    end
                    else
                    begin
                        walk_reg <= parent_reg[walk_reg];
                    end
                end
                S_JOIN:
                begin
                    cost_reg <= sum_w[COST_BITS] ? COST_MAX : sum_w[COST_BITS-1:0];
                    state_reg <= S_EMIT;
                end
                S_EMIT:
                begin
                    if (out_load)
                    begin
                        out_reg <= '{cur_reg.a, cur_reg.b, cur_reg.w, cost_reg, drop_reg, 1'b0};
                        n_reg <= n_reg + 1'b1;
                        state_reg <= S_EDGE_RD;
                    end
                end
                S_SUM:
                begin
                    if (out_load)
                    begin
                        out_reg <= '{'0, '0, '0, cost_reg, drop_reg, 1'b1};
                        count_reg <= '0;
                        cost_reg <= '0;
                        drop_reg <= 1'b0;
                        state_reg <= S_LOAD;
                    end
                end
                default:
                begin
                    state_reg <= S_LOAD;
                end
            endcase
        end
    end

    // Union-find forest: reset at the start of every run, linked by rank on a join.
    always_ff @(posedge clk)
    begin
        if (state_reg == S_INIT)
        begin
            for (int k = 0; k < MAX_VERTICES; k++)
            begin
                parent_reg[k] <= VBITS'(k);
                rank_reg[k] <= '0;
            end
        end
        else if (state_reg == S_JOIN)
        begin
            if (rank_reg[ra_reg] < rank_reg[walk_reg])
            begin
                parent_reg[ra_reg] <= walk_reg;
            end
            else
            begin
                parent_reg[walk_reg] <= ra_reg;
                if (rank_reg[ra_reg] == rank_reg[walk_reg])
                begin
                    rank_reg[ra_reg] <= rank_reg[ra_reg] + 1'b1;
                end
            end
        end
    end

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CBITS'(MAX_EDGES)) else $error("edge count overflow");
    a_sum_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SUM && (!out_valid_reg || out_ch.ready)) |=>
        (count_reg == '0 && state_reg == S_LOAD)) else $error("run did not close");
    a_tree_size: assert property (@(posedge clk) disable iff (!rst_n)
        n_reg <= (VBITS+1)'(MAX_VERTICES - 1)) else $error("too many tree edges");
`endif
endmodule
